>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer package
// Transaction kinds, character codes and fixed field widths.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_SCREEN_COLS = 80;
    localparam int DEF_SCREEN_ROWS = 25;

    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int CUR_COL_W = 7;
    localparam int CUR_ROW_W = 5;

    localparam logic [KIND_W-1:0] KIND_PRINT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SETPOS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd3;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [BYTE_W-1:0] BLANK_CODE   = 8'd0;

endpackage

>>> rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: text-mode screen store with cursor and scroll
// Character and attribute RAMs walked by a small sequencer with one shared
// row*cols+col address unit and one address counter.
// ----------------------------------------------------------------------------
// Set cursor and a print without scroll strobe o_done the cycle after accept;
// a read goes through the store read register and ST_READ; clear walks every
// cell in ST_BLANK; a scrolling print copies rows up in ST_SCR_RD/ST_SCR_WR,
// then blanks the last row. One RAM port pair per store sets these walks.
// busy blocks start during a read, clear or scroll; the receiver cannot stall
// results. Reset: synchronous; a clearing pass then zeroes both stores.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int SCREEN_COLS = DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [BYTE_W-1:0]    i_char_code,
    input  logic [BYTE_W-1:0]    i_attr,
    input  logic [BYTE_W-1:0]    i_col,
    input  logic [BYTE_W-1:0]    i_row,
    output logic                 busy,
    output logic                 o_done,
    output logic [CUR_COL_W-1:0] o_cursor_col,
    output logic [CUR_ROW_W-1:0] o_cursor_row,
    output logic [BYTE_W-1:0]    o_read_char,
    output logic [BYTE_W-1:0]    o_read_attr
);

    localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
    localparam int COL_W  = $clog2(SCREEN_COLS);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int CELL_W = $clog2(CELLS);

    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(SCREEN_COLS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [CELL_W-1:0] LAST_CELL  = CELL_W'(CELLS - 1);
    localparam logic [CELL_W-1:0] LAST_SHIFT = CELL_W'(CELLS - SCREEN_COLS - 1);
    localparam logic [CELL_W-1:0] ROW_STRIDE = CELL_W'(SCREEN_COLS);
    localparam logic [BYTE_W-1:0] COL_LIMIT  = BYTE_W'(SCREEN_COLS);
    localparam logic [BYTE_W-1:0] ROW_LIMIT  = BYTE_W'(SCREEN_ROWS);

    // sequencer states
    localparam logic [2:0] ST_INIT   = 3'd0;  // post-reset clear of both stores
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;  // cell read data arriving
    localparam logic [2:0] ST_SCR_RD = 3'd3;  // fetch char one row below
    localparam logic [2:0] ST_SCR_WR = 3'd4;  // write it one row up
    localparam logic [2:0] ST_BLANK  = 3'd5;  // zero chars up to the last cell

    // screen stores
    logic [BYTE_W-1:0] m_char [CELLS];
    logic [BYTE_W-1:0] m_attr [CELLS];

    logic [2:0]        r_state, n_state;
    logic [CELL_W-1:0] r_ptr, n_ptr;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_done, n_done;
    logic              r_rd_ok, n_rd_ok;
    logic [BYTE_W-1:0] r_out_char, n_out_char;
    logic [BYTE_W-1:0] r_out_attr, n_out_attr;
    logic [BYTE_W-1:0] r_char_q, r_attr_q;

    // RAM ports
    logic              w_ch_we, w_at_we;
    logic [CELL_W-1:0] w_ch_addr, w_at_addr, w_rd_addr;
    logic [BYTE_W-1:0] w_ch_data, w_at_data;

    // shared address unit: row * SCREEN_COLS + col
    logic [ROW_W-1:0]  w_mul_row;
    logic [COL_W-1:0]  w_mul_col;
    logic [CELL_W-1:0] w_lin;

    logic w_accept, w_in_range, w_newline;

    assign w_accept   = start && !busy;
    assign w_in_range = (i_col < COL_LIMIT) && (i_row < ROW_LIMIT);
    assign w_newline  = (i_char_code == NEWLINE_CODE);

    // reads address from the inputs, prints from the cursor
    assign w_mul_row = (i_kind == KIND_READ) ? i_row[ROW_W-1:0] : r_row;
    assign w_mul_col = (i_kind == KIND_READ) ? i_col[COL_W-1:0] : r_col;
    assign w_lin     = CELL_W'(w_mul_row) * ROW_STRIDE + CELL_W'(w_mul_col);

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_col      = r_col;
        n_row      = r_row;
        n_done     = 1'b0;
        n_rd_ok    = r_rd_ok;
        n_out_char = r_out_char;
        n_out_attr = r_out_attr;
        w_ch_we    = 1'b0;
        w_at_we    = 1'b0;
        w_ch_addr  = r_ptr;
        w_at_addr  = r_ptr;
        w_ch_data  = BLANK_CODE;
        w_at_data  = BLANK_CODE;
        w_rd_addr  = w_lin;

        unique case (r_state)
            ST_INIT: begin
                w_ch_we = 1'b1;
                w_at_we = 1'b1;
                n_ptr   = r_ptr + 1'b1;
                if (r_ptr == LAST_CELL) begin
                    n_ptr   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_char = BLANK_CODE;
                    n_out_attr = BLANK_CODE;
                    n_ptr      = '0;
                    unique case (i_kind)
                        KIND_PRINT: begin
                            if (!w_newline) begin
                                w_ch_we   = 1'b1;
                                w_at_we   = 1'b1;
                                w_ch_addr = w_lin;
                                w_at_addr = w_lin;
                                w_ch_data = i_char_code;
                                w_at_data = i_attr;
                            end
                            if (w_newline || r_col == LAST_COL) begin
                                n_col = '0;
                                if (r_row == LAST_ROW) begin
                                    n_state = ST_SCR_RD;
                                end else begin
                                    n_row  = r_row + 1'b1;
                                    n_done = 1'b1;
                                end
                            end else begin
                                n_col  = r_col + 1'b1;
                                n_done = 1'b1;
                            end
                        end
                        KIND_SETPOS: begin
                            if (i_col < COL_LIMIT) n_col = i_col[COL_W-1:0];
                            if (i_row < ROW_LIMIT) n_row = i_row[ROW_W-1:0];
                            n_done = 1'b1;
                        end
                        KIND_CLEAR: begin
                            n_state = ST_BLANK;
                        end
                        KIND_READ: begin
                            n_rd_ok = w_in_range;
                            n_state = ST_READ;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_out_char = r_rd_ok ? r_char_q : BLANK_CODE;
                n_out_attr = r_rd_ok ? r_attr_q : BLANK_CODE;
                n_done     = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_SCR_RD: begin
                w_rd_addr = r_ptr + ROW_STRIDE;
                n_state   = ST_SCR_WR;
            end
            ST_SCR_WR: begin
                w_ch_we   = 1'b1;
                w_ch_data = r_char_q;
                n_ptr     = r_ptr + 1'b1;
                n_state   = (r_ptr == LAST_SHIFT) ? ST_BLANK : ST_SCR_RD;
            end
            ST_BLANK: begin
                w_ch_we = 1'b1;
                n_ptr   = r_ptr + 1'b1;
                if (r_ptr == LAST_CELL) begin
                    n_ptr   = '0;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_ptr   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_done  <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_col   <= n_col;
            r_row   <= n_row;
            r_done  <= n_done;
            r_rd_ok <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_attr <= n_out_attr;
    end

    // character store
    always_ff @(posedge i_clk) begin
        if (w_ch_we) m_char[w_ch_addr] <= w_ch_data;
        r_char_q <= m_char[w_rd_addr];
    end

    // attribute store
    always_ff @(posedge i_clk) begin
        if (w_at_we) m_attr[w_at_addr] <= w_at_data;
        r_attr_q <= m_attr[w_rd_addr];
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_done       = r_done;
    assign o_cursor_col = CUR_COL_W'(r_col);
    assign o_cursor_row = CUR_ROW_W'(r_row);
    assign o_read_char  = r_out_char;
    assign o_read_attr  = r_out_attr;

`ifndef SYNTH
    a_cursor_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= LAST_COL) && (r_row <= LAST_ROW))
        else $error("cursor left the grid");

    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == ST_IDLE))
        else $error("result strobe outside idle");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_done || busy))
        else $error("accepted transaction neither finished nor in flight");

    a_scroll_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCR_RD || r_state == ST_SCR_WR) |-> (r_row == LAST_ROW))
        else $error("scroll with cursor off the last row");

    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCR_WR) |-> (r_ptr <= LAST_SHIFT))
        else $error("scroll copy past the last source row");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for text_console_writer
// Drives print, set cursor, clear and read transactions through the
// start/busy port with random idle gaps and checks every done strobe against
// an in-bench model of the screen store, cursor, wrap and upward scroll.
// ----------------------------------------------------------------------------
module tb;
    import tcw_pkg::*;

    localparam int COLS      = DEF_SCREEN_COLS;
    localparam int ROWS      = DEF_SCREEN_ROWS;
    localparam int CELLS     = COLS * ROWS;
    localparam int N_ITEMS   = 2000;
    localparam int MAX_GAP   = 12;
    // Each scroll walks the whole store, so the stimulus caps how many it asks
    // for; same for full clears.
    localparam int SCROLL_CAP = 110;
    localparam int CLEAR_CAP  = 30;
    localparam int SCROLL_LAT = 1 + 2 * (CELLS - COLS) + COLS;
    localparam int CLEAR_LAT  = CELLS + 1;
    localparam int TAIL_CYCLES = 64;
    localparam int MAX_PRINTED = 30;

    // One transaction toward the block, plus how it is to be launched.
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] attr;
        logic [BYTE_W-1:0] col;
        logic [BYTE_W-1:0] row;
        int unsigned       gap;    // idle cycles before start goes high
        bit                drain;  // hold off until all replies are in
    } console_cmd_t;

    // What the block reports after each transaction.
    typedef struct packed {
        logic [CUR_COL_W-1:0] cursor_col;
        logic [CUR_ROW_W-1:0] cursor_row;
        logic [BYTE_W-1:0]    read_char;
        logic [BYTE_W-1:0]    read_attr;
    } console_reply_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [KIND_W-1:0]    i_kind = KIND_PRINT;
    logic [BYTE_W-1:0]    i_char_code = '0;
    logic [BYTE_W-1:0]    i_attr = '0;
    logic [BYTE_W-1:0]    i_col = '0;
    logic [BYTE_W-1:0]    i_row = '0;
    logic                 busy;
    logic                 o_done;
    logic [CUR_COL_W-1:0] o_cursor_col;
    logic [CUR_ROW_W-1:0] o_cursor_row;
    logic [BYTE_W-1:0]    o_read_char;
    logic [BYTE_W-1:0]    o_read_attr;

    always #5 i_clk = ~i_clk;

    text_console_writer #(
        .SCREEN_COLS(COLS),
        .SCREEN_ROWS(ROWS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_attr       (i_attr),
        .i_col        (i_col),
        .i_row        (i_row),
        .busy         (busy),
        .o_done       (o_done),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_read_char  (o_read_char),
        .o_read_attr  (o_read_attr)
    );

    // ------------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------------
    console_cmd_t   command_q[$];        // transactions not yet launched
    console_reply_t console_replies_q[$]; // predicted replies, oldest first

    int unsigned cycle_cnt = 0;
    int unsigned cycle_limit = 0;
    int unsigned err_cnt = 0;
    int unsigned reply_cnt = 0;
    int unsigned idle_cnt = 0;
    bit          xact_taken = 1'b0;

    // Screen model: characters, attributes and cursor as the block keeps them.
    logic [BYTE_W-1:0] screen_char [CELLS];
    logic [BYTE_W-1:0] screen_attr [CELLS];
    int unsigned       cursor_c;
    int unsigned       cursor_r;
    int unsigned       kind_seen [4];
    int unsigned       scrolls_seen;
    int unsigned       oob_reads;

    // Generator side: a cursor shadow so scrolls and clears can be budgeted.
    int unsigned gen_col;
    int unsigned gen_row;
    int unsigned scrolls_planned;
    int unsigned clears_planned;
    bit          burst_mode;
    bit          drain_next;

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (err_cnt < MAX_PRINTED)
            $display("mismatch at reply %0d: %s got %0d expected %0d",
                     reply_cnt, what, got, want);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Screen model: applies one transaction, returns the reply it causes
    // ------------------------------------------------------------------------
    function automatic console_reply_t console_apply(input logic [KIND_W-1:0] kind,
                                                     input logic [BYTE_W-1:0] code,
                                                     input logic [BYTE_W-1:0] attr,
                                                     input logic [BYTE_W-1:0] col,
                                                     input logic [BYTE_W-1:0] row);
        console_reply_t rep;
        int unsigned    idx;
        rep = '0;
        kind_seen[kind]++;
        case (kind)
            KIND_PRINT: begin
                if (code == NEWLINE_CODE) begin
                    cursor_c = 0;
                    cursor_r++;
                end else begin
                    idx = cursor_r * COLS + cursor_c;
                    screen_char[idx] = code;
                    screen_attr[idx] = attr;
                    cursor_c++;
                end
                if (cursor_c >= COLS) begin
                    cursor_c = 0;
                    cursor_r++;
                end
                // Past the bottom: characters move up a row, attributes stay put.
                if (cursor_r >= ROWS) begin
                    cursor_r = ROWS - 1;
                    for (int i = 0; i < CELLS - COLS; i++)
                        screen_char[i] = screen_char[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++)
                        screen_char[i] = BLANK_CODE;
                    scrolls_seen++;
                end
            end
            KIND_SETPOS: begin
                // Each coordinate is taken on its own, only when inside the grid.
                if (col < COLS) cursor_c = col;
                if (row < ROWS) cursor_r = row;
            end
            KIND_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_char[i] = BLANK_CODE;
            end
            default: begin
                if (col < COLS && row < ROWS) begin
                    idx = row * COLS + col;
                    rep.read_char = screen_char[idx];
                    rep.read_attr = screen_attr[idx];
                end else begin
                    oob_reads++;
                end
            end
        endcase
        rep.cursor_col = CUR_COL_W'(cursor_c);
        rep.cursor_row = CUR_ROW_W'(cursor_r);
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [BYTE_W-1:0] rnd_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Mostly printable text, some newlines, some arbitrary bytes.
    function automatic logic [BYTE_W-1:0] text_byte();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) return NEWLINE_CODE;
        if (r == 1) return rnd_byte();
        return BYTE_W'($urandom_range(32, 126));
    endfunction

    // Queues one transaction. Tracks the cursor so that a scroll or a clear
    // over budget is turned into something cheap (home row / a read).
    task automatic queue_cmd(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] code,
                             input logic [BYTE_W-1:0] attr, input logic [BYTE_W-1:0] col,
                             input logic [BYTE_W-1:0] row);
        console_cmd_t c;
        bit           wraps;
        c.kind = kind;
        c.code = code;
        c.attr = attr;
        c.col  = col;
        c.row  = row;
        wraps  = 1'b0;
        if (c.kind == KIND_CLEAR && clears_planned >= CLEAR_CAP) c.kind = KIND_READ;
        if (c.kind == KIND_PRINT) begin
            wraps = (gen_row == ROWS - 1) && (code == NEWLINE_CODE || gen_col == COLS - 1);
            if (wraps && scrolls_planned >= SCROLL_CAP) begin
                c.kind = KIND_SETPOS;
                c.row  = '0;
            end
        end
        case (c.kind)
            KIND_PRINT: begin
                if (wraps) scrolls_planned++;
                if (code == NEWLINE_CODE || gen_col == COLS - 1) begin
                    gen_col = 0;
                    if (gen_row < ROWS - 1) gen_row++;
                end else begin
                    gen_col++;
                end
            end
            KIND_SETPOS: begin
                if (c.col < COLS) gen_col = c.col;
                if (c.row < ROWS) gen_row = c.row;
            end
            KIND_CLEAR: clears_planned++;
            default: ;
        endcase
        c.gap   = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        c.drain = drain_next;
        drain_next = 1'b0;
        command_q.push_back(c);
    endtask

    // ------------------------------------------------------------------------
    // Driver: launches queued transactions at the falling edge. start stays
    // high while busy; a zero-gap follower goes out back to back.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            idle_cnt <= 0;
        end else if (start && !xact_taken) begin
            // still waiting for the block to take the current transaction
        end else if (command_q.size() == 0) begin
            start <= 1'b0;
        end else if (command_q[0].drain && console_replies_q.size() != 0) begin
            start <= 1'b0;
        end else if (idle_cnt < command_q[0].gap) begin
            start    <= 1'b0;
            idle_cnt <= idle_cnt + 1;
        end else begin
            i_kind      <= command_q[0].kind;
            i_char_code <= command_q[0].code;
            i_attr      <= command_q[0].attr;
            i_col       <= command_q[0].col;
            i_row       <= command_q[0].row;
            start       <= 1'b1;
            idle_cnt    <= 0;
            command_q.delete(0);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks done strobes, then records newly accepted transactions.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        console_reply_t want;
        if (!i_rst_n) begin
            xact_taken <= 1'b0;
        end else begin
            xact_taken <= start && !busy;
            if (o_done) begin
                if (console_replies_q.size() == 0) begin
                    report_mismatch("reply with nothing pending", 1, 0);
                end else begin
                    want = console_replies_q.pop_front();
                    if (o_cursor_col !== want.cursor_col)
                        report_mismatch("cursor_col", o_cursor_col, want.cursor_col);
                    if (o_cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", o_cursor_row, want.cursor_row);
                    if (o_read_char !== want.read_char)
                        report_mismatch("read_char", o_read_char, want.read_char);
                    if (o_read_attr !== want.read_attr)
                        report_mismatch("read_attr", o_read_attr, want.read_attr);
                end
                reply_cnt++;
            end
            if (start && !busy)
                console_replies_q.push_back(console_apply(i_kind, i_char_code, i_attr,
                                                          i_col, i_row));
        end
    end

    // Reset is held from time zero, released on a falling edge, never again.
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Stimulus build and end of run
    // ------------------------------------------------------------------------
    initial begin : main
        int unsigned pick;
        bit          timed_out;
        timed_out = 1'b0;
        for (int i = 0; i < CELLS; i++) begin
            screen_char[i] = BLANK_CODE;
            screen_attr[i] = BLANK_CODE;
        end
        cursor_c = 0;
        cursor_r = 0;
        scrolls_seen = 0;
        oob_reads = 0;
        for (int k = 0; k < 4; k++) kind_seen[k] = 0;
        gen_col = 0;
        gen_row = 0;
        scrolls_planned = 0;
        clears_planned = 0;
        burst_mode = 1'b0;
        drain_next = 1'b0;

        // Directed: corners of the grid, wrap, scroll, clear, bad coordinates.
        queue_cmd(KIND_READ,   8'h00, 8'h00, 8'd0, 8'd0);            // fresh store
        queue_cmd(KIND_PRINT,  8'h41, 8'hFF, 8'hFF, 8'hFF);
        queue_cmd(KIND_READ,   8'h00, 8'h00, 8'd0, 8'd0);
        queue_cmd(KIND_PRINT,  NEWLINE_CODE, 8'h77, 8'd0, 8'd0);     // newline
        queue_cmd(KIND_SETPOS, 8'h00, 8'h00, 8'(COLS - 1), 8'hFF);  // row ignored
        queue_cmd(KIND_PRINT,  8'hFF, 8'h00, 8'd0, 8'd0);            // wraps at row end
        queue_cmd(KIND_READ,   8'h00, 8'h00, 8'(COLS - 1), 8'd1);
        queue_cmd(KIND_SETPOS, 8'h00, 8'h00, 8'd200, 8'(ROWS - 1)); // col ignored
        queue_cmd(KIND_SETPOS, 8'h00, 8'h00, 8'(COLS - 1), 8'(ROWS - 1));
        queue_cmd(KIND_PRINT,  8'h5A, 8'hA5, 8'd0, 8'd0);            // wrap past bottom
        drain_next = 1'b1;                                           // let the scroll finish
        queue_cmd(KIND_READ,   8'h00, 8'h00, 8'(COLS - 1), 8'(ROWS - 1));
        queue_cmd(KIND_READ,   8'h00, 8'h00, 8'(COLS - 1), 8'(ROWS - 2));
        queue_cmd(KIND_PRINT,  NEWLINE_CODE, 8'h00, 8'd0, 8'd0);     // newline on last row
        queue_cmd(KIND_READ,   8'h00, 8'h00, 8'(COLS), 8'd0);
        queue_cmd(KIND_READ,   8'h00, 8'h00, 8'd0, 8'(ROWS));
        queue_cmd(KIND_READ,   8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_cmd(KIND_SETPOS, 8'hFF, 8'hFF, 8'hFF, 8'hFF);          // both ignored
        queue_cmd(KIND_CLEAR,  8'h00, 8'h00, 8'd0, 8'd0);
        queue_cmd(KIND_READ,   8'h00, 8'h00, 8'(COLS - 1), 8'(ROWS - 1));
        queue_cmd(KIND_SETPOS, 8'h00, 8'h00, 8'd0, 8'd0);
        queue_cmd(KIND_PRINT,  8'h00, 8'h00, 8'd0, 8'd0);
        queue_cmd(KIND_READ,   8'h00, 8'h00, 8'd0, 8'd0);

        // Random: mostly text runs, bottom-of-screen runs and readbacks,
        // with some raw noise, bad coordinates, clears and drain pauses.
        while (command_q.size() < N_ITEMS) begin
            pick = $urandom_range(0, 99);
            burst_mode = ($urandom_range(0, 3) == 0);
            if (pick < 45) begin
                if ($urandom_range(0, 1) == 1)
                    queue_cmd(KIND_SETPOS, rnd_byte(), rnd_byte(),
                              8'($urandom_range(0, COLS - 1)), 8'($urandom_range(0, ROWS - 1)));
                repeat ($urandom_range(5, 30))
                    queue_cmd(KIND_PRINT, text_byte(), rnd_byte(), rnd_byte(), rnd_byte());
            end else if (pick < 57) begin
                queue_cmd(KIND_SETPOS, rnd_byte(), rnd_byte(),
                          8'(COLS - 1 - $urandom_range(0, 6)), 8'(ROWS - 1));
                repeat ($urandom_range(3, 10))
                    queue_cmd(KIND_PRINT, text_byte(), rnd_byte(), rnd_byte(), rnd_byte());
                repeat ($urandom_range(1, 4))
                    queue_cmd(KIND_READ, rnd_byte(), rnd_byte(),
                              8'($urandom_range(0, COLS - 1)),
                              8'(ROWS - 1 - $urandom_range(0, 1)));
            end else if (pick < 77) begin
                repeat ($urandom_range(3, 8)) begin
                    if ($urandom_range(0, 2) == 0)
                        queue_cmd(KIND_READ, rnd_byte(), rnd_byte(),
                                  8'(gen_col > 0 ? gen_col - 1 : 0), 8'(gen_row));
                    else
                        queue_cmd(KIND_READ, rnd_byte(), rnd_byte(),
                                  8'($urandom_range(0, COLS - 1)),
                                  8'($urandom_range(0, 1) == 1 ? gen_row
                                                               : $urandom_range(0, ROWS - 1)));
                end
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 5))
                    queue_cmd(KIND_W'($urandom_range(0, 3)), rnd_byte(), rnd_byte(),
                              rnd_byte(), rnd_byte());
            end else if (pick < 94) begin
                case ($urandom_range(0, 2))
                    0: queue_cmd(KIND_SETPOS, rnd_byte(), rnd_byte(), 8'(COLS), rnd_byte());
                    1: queue_cmd(KIND_SETPOS, rnd_byte(), rnd_byte(), rnd_byte(), 8'(ROWS));
                    default: queue_cmd(KIND_SETPOS, rnd_byte(), rnd_byte(),
                                       rnd_byte(), rnd_byte());
                endcase
            end else if (pick < 97) begin
                queue_cmd(KIND_CLEAR, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
            end else begin
                drain_next = 1'b1;
                queue_cmd(KIND_READ, rnd_byte(), rnd_byte(),
                          8'($urandom_range(0, COLS - 1)), 8'($urandom_range(0, ROWS - 1)));
            end
        end

        // Budget: reset clearing pass, every transaction at full gap, every
        // planned scroll and clear walk, then four times that.
        cycle_limit = 4 * (CELLS + command_q.size() * (MAX_GAP + 4)
                           + scrolls_planned * SCROLL_LAT + clears_planned * CLEAR_LAT)
                      + 10000;

        while ((command_q.size() != 0 || start || console_replies_q.size() != 0)
               && cycle_cnt < cycle_limit)
            @(negedge i_clk);
        if (cycle_cnt >= cycle_limit) timed_out = 1'b1;
        else repeat (TAIL_CYCLES) @(negedge i_clk);

        if (timed_out) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_cnt, console_replies_q.size());
            err_cnt++;
        end
        while (console_replies_q.size() != 0) begin
            report_mismatch("reply never arrived", 0, 1);
            void'(console_replies_q.pop_front());
        end

        $display("ran %0d transactions: %0d prints, %0d cursor moves, %0d clears, %0d reads",
                 reply_cnt, kind_seen[KIND_PRINT], kind_seen[KIND_SETPOS],
                 kind_seen[KIND_CLEAR], kind_seen[KIND_READ]);
        $display("scrolls %0d, out-of-grid reads %0d, mismatches %0d, cycles %0d",
                 scrolls_seen, oob_reads, err_cnt, cycle_cnt);
        if (err_cnt == 0)
            $display("[text_console_writer] OK");
        else
            $display("[text_console_writer] ERROR");
        $finish;
    end

endmodule

>>> text_console_writer.f
rtl/tcw_pkg.sv
rtl/text_console_writer.sv
verif/tb.sv
